>>> rtl/cht_pkg.sv
package cht_pkg;

  localparam int unsigned Buckets = 64;
  localparam int unsigned Nodes = 256;
  localparam int unsigned BucketW = $clog2(Buckets);
  localparam int unsigned NodeW = $clog2(Nodes);
  localparam int unsigned LinkW = NodeW + 1;
  localparam int unsigned CountW = 7;
  localparam int unsigned KeyW = 16;
  localparam int unsigned ValW = 32;
  localparam int unsigned FuncW = 2;
  localparam int unsigned StepW = NodeW + 1;

  localparam logic [LinkW-1:0] NullLink = LinkW'(Nodes);

  localparam logic [FuncW-1:0] FuncInsert = 2'd0;
  localparam logic [FuncW-1:0] FuncLookup = 2'd1;
  localparam logic [FuncW-1:0] FuncContains = 2'd2;
  localparam logic [FuncW-1:0] FuncRemove = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // latch input word, start modulo
    logic mod_step;   // one restoring subtract step
    logic init_step;  // one free-list init write
    logic rd_head;    // read bucket head
    logic rd_node;    // read node at cursor
    logic advance;    // move cursor along chain
    logic do_insert;
    logic do_unlink;  // rewrite predecessor link or head
    logic do_free;    // push removed node onto free list
    logic set_found;
    logic set_full;
  } cht_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic init_done;
    logic cur_null;
    logic key_hit;
    logic walk_limit;
    logic pool_empty;
    logic [FuncW-1:0] func;
  } cht_sts_t;

endpackage

>>> rtl/cht_datapath.sv
module cht_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cht_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic [cht_pkg::FuncW-1:0]    func_i,
  input  logic [cht_pkg::KeyW-1:0]     key_i,
  input  logic [cht_pkg::ValW-1:0]     value_i,
  input  cht_pkg::cht_cmd_t            cmd_i,
  input  logic                         sel_free_i,
  output cht_pkg::cht_sts_t            sts_o,
  output logic                         found_o,
  output logic [cht_pkg::ValW-1:0]     result_value_o,
  output logic                         status_o
);

  logic [cht_pkg::CountW-1:0] count_q;
  logic [cht_pkg::FuncW-1:0]  func_q;
  logic [cht_pkg::KeyW-1:0]   key_q;
  logic [cht_pkg::ValW-1:0]   val_q;
  logic [cht_pkg::KeyW-1:0]   rem_q;
  logic [4:0]                 mod_cnt_q;
  logic [cht_pkg::CountW-1:0] div_eff;
  logic [cht_pkg::KeyW+cht_pkg::CountW-1:0] div_sh;
  logic [cht_pkg::LinkW-1:0]  head_mem [cht_pkg::Buckets];
  logic [cht_pkg::KeyW-1:0]   key_mem  [cht_pkg::Nodes];
  logic [cht_pkg::ValW-1:0]   val_mem  [cht_pkg::Nodes];
  logic [cht_pkg::LinkW-1:0]  next_mem [cht_pkg::Nodes];
  logic [cht_pkg::LinkW-1:0]  free_q;
  logic [cht_pkg::LinkW-1:0]  cur_q;
  logic [cht_pkg::LinkW-1:0]  prev_q;
  logic [cht_pkg::KeyW-1:0]   nkey_q;
  logic [cht_pkg::ValW-1:0]   nval_q;
  logic [cht_pkg::LinkW-1:0]  nnext_q;
  logic [cht_pkg::LinkW-1:0]  head_rd_q;
  logic [cht_pkg::StepW-1:0]  steps_q;
  logic [cht_pkg::LinkW-1:0]  init_q;
  logic [cht_pkg::BucketW-1:0] bkt;
  logic [cht_pkg::NodeW-1:0]  cur_idx;

  always_comb begin
    div_eff = count_q;
    if (count_q == '0) div_eff = cht_pkg::CountW'(1);
    if (count_q > cht_pkg::CountW'(cht_pkg::Buckets)) begin
      div_eff = cht_pkg::CountW'(cht_pkg::Buckets);
    end
  end

  // restoring division, divisor shifted from bit 15 down to bit 0
  assign div_sh = {{cht_pkg::KeyW{1'b0}}, div_eff} << (5'd15 - mod_cnt_q);
  assign bkt = rem_q[cht_pkg::BucketW-1:0];
  assign cur_idx = cur_q[cht_pkg::NodeW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= cht_pkg::CountW'(cht_pkg::Buckets);
      mod_cnt_q <= '0;
      free_q <= '0;
      init_q <= '0;
      steps_q <= '0;
      found_o <= 1'b0;
      status_o <= 1'b0;
      result_value_o <= '0;
    end else begin
      if (cfg_we_i) count_q <= cfg_wdata_i;
      if (cmd_i.init_step) init_q <= init_q + cht_pkg::LinkW'(1);
      if (cmd_i.load) begin
        mod_cnt_q <= '0;
        found_o <= 1'b0;
        status_o <= 1'b0;
        result_value_o <= '0;
      end
      if (cmd_i.mod_step) mod_cnt_q <= mod_cnt_q + 5'd1;
      if (cmd_i.rd_head) steps_q <= '0;
      if (cmd_i.advance) steps_q <= steps_q + cht_pkg::StepW'(1);
      if (cmd_i.set_full) status_o <= 1'b1;
      if (cmd_i.set_found) begin
        found_o <= 1'b1;
        if (func_q == cht_pkg::FuncLookup) result_value_o <= nval_q;
      end
      if (cmd_i.do_insert) free_q <= nnext_q;
      if (cmd_i.do_free) free_q <= cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      key_q <= key_i;
      val_q <= value_i;
      rem_q <= key_i;
    end
    if (cmd_i.mod_step && ({{cht_pkg::CountW{1'b0}}, rem_q} >= div_sh)) begin
      rem_q <= cht_pkg::KeyW'({{cht_pkg::CountW{1'b0}}, rem_q} - div_sh);
    end
    if (cmd_i.rd_head) begin
      head_rd_q <= head_mem[bkt];
      prev_q <= cht_pkg::NullLink;
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      cur_q <= nnext_q;
    end
    if (cmd_i.rd_head) cur_q <= head_mem[bkt];
    // insert reads the free node through the same port
    if (cmd_i.rd_node) begin
      nkey_q <= key_mem[cur_idx];
      nval_q <= val_mem[cur_idx];
      nnext_q <= next_mem[cur_idx];
    end
    if (cmd_i.init_step) begin
      if (init_q < cht_pkg::LinkW'(cht_pkg::Buckets)) begin
        head_mem[init_q[cht_pkg::BucketW-1:0]] <= cht_pkg::NullLink;
      end
      next_mem[init_q[cht_pkg::NodeW-1:0]] <= init_q + cht_pkg::LinkW'(1);
    end
    if (cmd_i.do_insert) begin
      key_mem[cur_idx] <= key_q;
      val_mem[cur_idx] <= val_q;
      next_mem[cur_idx] <= head_rd_q;
      head_mem[bkt] <= cur_q;
    end
    if (cmd_i.do_unlink) begin
      if (prev_q == cht_pkg::NullLink) head_mem[bkt] <= nnext_q;
      else next_mem[prev_q[cht_pkg::NodeW-1:0]] <= nnext_q;
    end
    if (cmd_i.do_free) next_mem[cur_idx] <= free_q;
    // insert: cursor set to free head after head read
    if (sel_free_i) cur_q <= free_q;
  end

  assign sts_o.mod_done = (mod_cnt_q == 5'd16);
  assign sts_o.init_done = (init_q == cht_pkg::LinkW'(cht_pkg::Nodes - 1));
  assign sts_o.cur_null = (cur_q >= cht_pkg::NullLink);
  assign sts_o.key_hit = (nkey_q == key_q);
  assign sts_o.walk_limit = (steps_q >= cht_pkg::StepW'(cht_pkg::Nodes));
  assign sts_o.pool_empty = (free_q >= cht_pkg::NullLink);
  assign sts_o.func = func_q;

endmodule

>>> rtl/cht_ctrl.sv
module cht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  cht_pkg::cht_sts_t sts_i,
  output cht_pkg::cht_cmd_t cmd_o,
  output logic              sel_free_o,
  output logic              out_load_o
);

  typedef enum logic [3:0] {
    StInit, StIdle, StMod, StHead, StFree, StIns, StRead, StCheck, StUnlink, StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    busy_d = busy_q;
    cmd_o = '0;
    sel_free_o = 1'b0;
    out_load_o = 1'b0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      StInit: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_done) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i && !busy_q) begin
          cmd_o.load = 1'b1;
          busy_d = 1'b1;
          state_d = StMod;
        end
      end
      StMod: begin
        if (sts_i.mod_done) begin
          cmd_o.rd_head = 1'b1;
          state_d = StHead;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      StHead: begin
        if (sts_i.func == cht_pkg::FuncInsert) begin
          if (sts_i.pool_empty) begin
            cmd_o.set_full = 1'b1;
            state_d = StDone;
          end else begin
            sel_free_o = 1'b1;
            state_d = StFree;
          end
        end else if (sts_i.cur_null) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_node = 1'b1;
          state_d = StCheck;
        end
      end
      StFree: begin
        cmd_o.rd_node = 1'b1;
        state_d = StIns;
      end
      StIns: begin
        cmd_o.do_insert = 1'b1;
        state_d = StDone;
      end
      StCheck: begin
        if (sts_i.key_hit) begin
          cmd_o.set_found = 1'b1;
          state_d = (sts_i.func == cht_pkg::FuncRemove) ? StUnlink : StDone;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (sts_i.cur_null || sts_i.walk_limit) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_node = 1'b1;
          state_d = StCheck;
        end
      end
      StUnlink: begin
        cmd_o.do_unlink = 1'b1;
        cmd_o.do_free = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_load_o = 1'b1;
          busy_d = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      out_valid_q <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      busy_q <= busy_d;
    end
  end

  assign in_stall_o = (state_q != StIdle) || busy_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/chained_hash_table.sv
// Chained hash table over 64 bucket heads and a pool of 256 nodes. After
// reset the block builds the free list and clears the bucket heads, with
// in_stall_o high. Each word is then taken, reduced to its bucket by a
// modulo (one restoring-divide bit per cycle), and the bucket head is read
// and checked before the word finishes; each chain node visited is read
// through the single node memory read port and then checked. An insert
// adds a free-node read and a write, and a remove hit adds an unlink. One
// word is in flight at a time, and the next word is taken once the finished
// result has moved to the output register. The user must see that
// bucket_count is written only while idle; the block does not enforce it.
module chained_hash_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cht_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cht_pkg::FuncW-1:0]    func_i,
  input  logic [cht_pkg::KeyW-1:0]     key_i,
  input  logic [cht_pkg::ValW-1:0]     value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [cht_pkg::ValW-1:0]     result_value_o,
  output logic                         status_o
);

  cht_pkg::cht_cmd_t cmd;
  cht_pkg::cht_sts_t sts;
  logic sel_free;
  logic out_load;
  logic fin_found, fin_status;
  logic [cht_pkg::ValW-1:0] fin_val;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd), .sel_free_o(sel_free), .out_load_o(out_load)
  );

  cht_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .func_i, .key_i, .value_i,
    .cmd_i(cmd), .sel_free_i(sel_free), .sts_o(sts),
    .found_o(fin_found), .result_value_o(fin_val), .status_o(fin_status)
  );

  // result register loads when the controller raises out valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_o <= 1'b0;
      result_value_o <= '0;
      status_o <= 1'b0;
    end else if (out_load) begin
      found_o <= fin_found;
      result_value_o <= fin_val;
      status_o <= fin_status;
    end
  end

endmodule
